### hdl/tcw_pkg.sv
package tcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);

	localparam int CHAR_W     = 8;
	localparam int ATTR_W     = 8;
	localparam int CELL_W     = ATTR_W + CHAR_W;
	localparam int IDX_W      = 11;
	localparam int OUT_COL_W  = 7;
	localparam int OUT_ROW_W  = 5;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;
	localparam int WIDE_W     = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

	localparam int TAB_STEP = 4;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7F;
	localparam logic [CHAR_W-1:0] SPACE    = 8'h20;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
	localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, SPACE};

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDATA,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             store;
		logic             scroll;
	} cursor_upd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

	// logical offset plus ring base, folded once into the screen
	function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] ofs,
		input logic [ADDR_W-1:0] base);
		logic [ADDR_W:0] sum;
		sum = {1'b0, ofs} + {1'b0, base};
		if (sum >= (ADDR_W+1)'(CELL_COUNT)) begin
			sum = sum - (ADDR_W+1)'(CELL_COUNT);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

### hdl/tcw_cell_ram.sv
module tcw_cell_ram (
	input  logic                       clk,
	input  tcw_pkg::ram_wr_t           wr,
	input  tcw_pkg::ram_rd_t           rd,
	output logic [tcw_pkg::CELL_W-1:0] rd_data
);

	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

### hdl/tcw_cursor.sv
module tcw_cursor (
	input  logic [tcw_pkg::COL_W-1:0]  col,
	input  logic [tcw_pkg::ROW_W-1:0]  row,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	output tcw_pkg::cursor_upd_t       upd
);

	localparam int CW = tcw_pkg::COL_W + 1;
	localparam int RW = tcw_pkg::ROW_W + 1;

	logic [CW-1:0] c;
	logic [RW-1:0] r;

	always_comb begin
		c = {1'b0, col};
		r = {1'b0, row};
		upd.store  = 1'b0;
		upd.scroll = 1'b0;
		case (char_code)
			tcw_pkg::CH_BS: begin
				if (col != '0) begin
					c = c - CW'(1);
				end
			end
			tcw_pkg::CH_TAB: begin
				c = (c + CW'(tcw_pkg::TAB_STEP)) & ~CW'(tcw_pkg::TAB_STEP - 1);
			end
			tcw_pkg::CH_CR: begin
				c = '0;
			end
			tcw_pkg::CH_LF: begin
				c = '0;
				r = r + RW'(1);
			end
			default: begin
				if (char_code inside {[tcw_pkg::PRINT_LO:tcw_pkg::PRINT_HI]}) begin
					upd.store = 1'b1;
					c = c + CW'(1);
				end
			end
		endcase
		if (c >= CW'(tcw_pkg::COLUMNS)) begin
			c = '0;
			r = r + RW'(1);
		end
		if (r >= RW'(tcw_pkg::ROWS)) begin
			r = RW'(tcw_pkg::ROWS - 1);
			upd.scroll = 1'b1;
		end
		upd.col = c[tcw_pkg::COL_W-1:0];
		upd.row = r[tcw_pkg::ROW_W-1:0];
	end

endmodule

### hdl/text_console_char_writer.sv
// Text console character writer.
// Input channel s_*: one word per item. s_tuser is the op (0 put, 1 read);
// s_tdata carries the character byte and the index of the cell to read.
// Output channel m_*: exactly one result word per item, with the read cell
// (zero for a put), the cursor after the item and a scroll flag.
// cfg_*: writes the attribute byte used for every stored cell; always ready.
// One item is handled at a time. A put loads its result in the execute
// state; a read issues the screen memory read there and loads its result
// in the read-data state. A new item is taken in the cycle after the
// result is loaded, or after the row clear when the put scrolled.
// The screen is a ring of rows in one memory; a scroll moves the ring base
// and clears the freed row, one cell per cycle; no item is taken meanwhile.
// After reset the memory is swept to spaces with attribute 7, one cell per
// cycle; s_tready stays low during the sweep.
// A stalled receiver holds the result in the output register; the block
// takes the next item, then waits before loading its result.
module text_console_char_writer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tcw_pkg::IN_DATA_W-1:0]  s_tdata,  // char_code[7:0], cell_index[18:8], pad
	input  logic                           s_tuser,  // op[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tcw_pkg::OUT_DATA_W-1:0] m_tdata,  // cell_value[15:0], cursor_col[22:16],
	                                                 // cursor_row[27:23], scrolled[28], pad
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data
);

	tcw_pkg::state_t state_q, state_d;

	logic [tcw_pkg::COL_W-1:0]  col_q;
	logic [tcw_pkg::ROW_W-1:0]  row_q;
	logic [tcw_pkg::ADDR_W-1:0] base_q;
	logic [tcw_pkg::ADDR_W-1:0] clr_base_q;
	logic [tcw_pkg::ADDR_W-1:0] cnt_q;
	logic [tcw_pkg::ATTR_W-1:0] attr_q;

	tcw_pkg::op_t               op_s1;
	logic [tcw_pkg::CHAR_W-1:0] char_s1;
	logic [tcw_pkg::IDX_W-1:0]  idx_s1;

	logic                          m_valid_q;
	logic [tcw_pkg::CELL_W-1:0]    out_cell_q;
	logic [tcw_pkg::OUT_COL_W-1:0] out_col_q;
	logic [tcw_pkg::OUT_ROW_W-1:0] out_row_q;
	logic                          out_scr_q;

	tcw_pkg::cursor_upd_t       upd;
	tcw_pkg::ram_wr_t           wr;
	tcw_pkg::ram_rd_t           rd;
	logic [tcw_pkg::CELL_W-1:0] rd_data;

	logic                       accept;
	logic                       out_free;
	logic                       load_put;
	logic                       load_read;
	logic                       idx_in_range;
	logic [tcw_pkg::ADDR_W-1:0] cur_ofs;
	logic [tcw_pkg::ADDR_W-1:0] base_adv;

	tcw_cursor u_cursor (
		.col       (col_q),
		.row       (row_q),
		.char_code (char_s1),
		.upd       (upd)
	);

	tcw_cell_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	assign idx_in_range = tcw_pkg::WIDE_W'(idx_s1) < tcw_pkg::WIDE_W'(tcw_pkg::CELL_COUNT);
	assign cur_ofs = tcw_pkg::ADDR_W'(row_q) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)
		+ tcw_pkg::ADDR_W'(col_q);
	assign base_adv = tcw_pkg::ring_addr(tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS), base_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				if (cnt_q == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = tcw_pkg::ST_EXEC;
				end
			end
			tcw_pkg::ST_EXEC: begin
				if (op_s1 == tcw_pkg::OP_READ) begin
					state_d = tcw_pkg::ST_RDATA;
				end else if (out_free) begin
					state_d = upd.scroll ? tcw_pkg::ST_CLEAR : tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_RDATA: begin
				if (out_free) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_CLEAR: begin
				if (cnt_q == tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS - 1)) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		load_put  = 1'b0;
		load_read = 1'b0;
		wr.en     = 1'b0;
		wr.addr   = cnt_q;
		wr.data   = tcw_pkg::RESET_CELL;
		rd.en     = 1'b0;
		rd.addr   = tcw_pkg::ring_addr(tcw_pkg::ADDR_W'(idx_s1), base_q);
		case (state_q)
			tcw_pkg::ST_INIT: begin
				wr.en = 1'b1;
			end
			tcw_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			tcw_pkg::ST_EXEC: begin
				if (op_s1 == tcw_pkg::OP_READ) begin
					rd.en = idx_in_range;
				end else if (out_free) begin
					load_put = 1'b1;
					wr.en    = upd.store;
					wr.addr  = tcw_pkg::ring_addr(cur_ofs, base_q);
					wr.data  = {attr_q, char_s1};
				end
			end
			tcw_pkg::ST_RDATA: begin
				load_read = out_free;
			end
			tcw_pkg::ST_CLEAR: begin
				wr.en   = 1'b1;
				wr.addr = clr_base_q + cnt_q;
				wr.data = {attr_q, tcw_pkg::SPACE};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tcw_pkg::ST_INIT;
			col_q      <= '0;
			row_q      <= '0;
			base_q     <= '0;
			clr_base_q <= '0;
			cnt_q      <= '0;
			attr_q     <= tcw_pkg::ATTR_RESET;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
			if (state_q == tcw_pkg::ST_INIT || state_q == tcw_pkg::ST_CLEAR) begin
				cnt_q <= cnt_q + tcw_pkg::ADDR_W'(1);
			end
			if (load_put) begin
				col_q <= upd.col;
				row_q <= upd.row;
				cnt_q <= '0;
				if (upd.scroll) begin
					clr_base_q <= base_q;
					base_q     <= base_adv;
				end
			end
			if (load_put || load_read) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= tcw_pkg::op_t'(s_tuser);
			char_s1 <= s_tdata[tcw_pkg::CHAR_W-1:0];
			idx_s1  <= s_tdata[tcw_pkg::CHAR_W +: tcw_pkg::IDX_W];
		end
		if (load_put) begin
			out_cell_q <= '0;
			out_col_q  <= tcw_pkg::OUT_COL_W'(upd.col);
			out_row_q  <= tcw_pkg::OUT_ROW_W'(upd.row);
			out_scr_q  <= upd.scroll;
		end
		if (load_read) begin
			out_cell_q <= idx_in_range ? rd_data : '0;
			out_col_q  <= tcw_pkg::OUT_COL_W'(col_q);
			out_row_q  <= tcw_pkg::OUT_ROW_W'(row_q);
			out_scr_q  <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = tcw_pkg::OUT_DATA_W'({out_scr_q, out_row_q, out_col_q, out_cell_q});

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("item accepted while another is in flight");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) && (row_q < tcw_pkg::ROW_W'(tcw_pkg::ROWS)))
		else $error("cursor outside the screen");

	a_scroll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load_put && upd.scroll) |=> (state_q == tcw_pkg::ST_CLEAR && cnt_q == '0))
		else $error("scroll without row clear");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (tcw_pkg::WIDE_W'(wr.addr) < tcw_pkg::WIDE_W'(tcw_pkg::CELL_COUNT)))
		else $error("write beyond the screen");

	a_no_read_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd.en |-> !wr.en)
		else $error("read and write in the same cycle");

endmodule
